@@ src/p2a_pkg.sv @@
package p2a_pkg;

    // configuration register file
    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_HEIGHT = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_TEXT_COLUMNS  = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_TEXT_ROWS     = CFG_IDX_W'(3);

    localparam logic [CFG_W-1:0] RST_SOURCE_WIDTH  = CFG_W'(640);
    localparam logic [CFG_W-1:0] RST_SOURCE_HEIGHT = CFG_W'(480);
    localparam logic [CFG_W-1:0] RST_TEXT_COLUMNS  = CFG_W'(80);
    localparam logic [CFG_W-1:0] RST_TEXT_ROWS     = CFG_W'(24);

    localparam int DEF_MAX_DIMENSION = 4096;

    // stream payload
    localparam int PIX_W     = 8;
    localparam int S_DATA_W  = 3 * PIX_W;
    localparam int GLYPH_W   = 7;
    localparam int M_DATA_W  = 8;

    // queue between classifier and luma pipeline
    localparam int QUEUE_DEPTH = 4;

    // BT.601 luma, weights in thousandths
    localparam int SUM_W   = 18;
    localparam logic [SUM_W-1:0] WEIGHT_R = SUM_W'(299);
    localparam logic [SUM_W-1:0] WEIGHT_G = SUM_W'(587);
    localparam logic [SUM_W-1:0] WEIGHT_B = SUM_W'(114);

    // divide by 1000 as multiply by ceil(2^28/1000), exact for sums below 2^18
    localparam int RECIP_W    = 19;
    localparam int LUMA_SHIFT = 28;
    localparam logic [RECIP_W-1:0] LUMA_RECIP = RECIP_W'(268436);
    localparam int PROD_W     = SUM_W + RECIP_W;

    localparam int IDX_W      = 5;
    localparam int SCALE_W    = 13;
    localparam logic [SCALE_W-1:0] PALETTE_TOP = SCALE_W'(22);

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
        logic             row_end;
        logic             frame_end;
    } p2a_item_t;

    // palette, dark to bright: "   ...',;:clodxkO0KXNWM"
    function automatic logic [GLYPH_W-1:0] palette_glyph(input logic [IDX_W-1:0] idx);
        logic [GLYPH_W-1:0] g;
        case (idx)
            5'd0, 5'd1, 5'd2: g = 7'h20; // space
            5'd3, 5'd4, 5'd5: g = 7'h2E; // .
            5'd6:  g = 7'h27; // '
            5'd7:  g = 7'h2C; // ,
            5'd8:  g = 7'h3B; // ;
            5'd9:  g = 7'h3A; // :
            5'd10: g = 7'h63; // c
            5'd11: g = 7'h6C; // l
            5'd12: g = 7'h6F; // o
            5'd13: g = 7'h64; // d
            5'd14: g = 7'h78; // x
            5'd15: g = 7'h6B; // k
            5'd16: g = 7'h4F; // O
            5'd17: g = 7'h30; // 0
            5'd18: g = 7'h4B; // K
            5'd19: g = 7'h58; // X
            5'd20: g = 7'h4E; // N
            5'd21: g = 7'h57; // W
            default: g = 7'h4D; // M, brightest
        endcase
        return g;
    endfunction

    // glyph for a luma value: index floor(luma*22/255), /255 done as
    // (x + (x >> 8) + 1) >> 8, exact for x up to 65534
    function automatic logic [GLYPH_W-1:0] luma_glyph(input logic [PIX_W-1:0] luma);
        logic [SCALE_W-1:0] x;
        logic [SCALE_W-1:0] q;
        x = SCALE_W'(luma) * PALETTE_TOP;
        q = (x + (x >> 8) + SCALE_W'(1)) >> 8;
        return palette_glyph(q[IDX_W-1:0]);
    endfunction

endpackage

@@ src/p2a_front.sv @@
module p2a_front import p2a_pkg::*; #(
    parameter int MAX_DIMENSION = DEF_MAX_DIMENSION
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // pixel side
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_DATA_W-1:0]  s_tdata,
    // configuration writes
    input  logic                 cfg_valid,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    // to the queue
    input  logic                 q_full,
    output logic                 q_push,
    output p2a_item_t            q_item
);

    localparam int DW = $clog2(MAX_DIMENSION + 1);
    localparam int CW = $clog2(MAX_DIMENSION);
    localparam int PW = 2 * DW;
    localparam int XW = (DW > CFG_W) ? DW : CFG_W;

    function automatic logic [DW-1:0] clamp_dim(input logic [XW-1:0] v,
                                               input logic [XW-1:0] cap);
        logic [DW-1:0] r;
        if (v == '0) begin
            r = DW'(1);
        end else if (v > cap) begin
            r = cap[DW-1:0];
        end else begin
            r = v[DW-1:0];
        end
        return r;
    endfunction

    // raw size registers
    logic [CFG_W-1:0] src_w_reg, src_h_reg, cols_reg, rows_reg;
    logic             cfg_hit;

    assign cfg_hit = cfg_valid && ((cfg_index == REG_SOURCE_WIDTH) ||
                                   (cfg_index == REG_SOURCE_HEIGHT) ||
                                   (cfg_index == REG_TEXT_COLUMNS) ||
                                   (cfg_index == REG_TEXT_ROWS));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_w_reg <= RST_SOURCE_WIDTH;
            src_h_reg <= RST_SOURCE_HEIGHT;
            cols_reg  <= RST_TEXT_COLUMNS;
            rows_reg  <= RST_TEXT_ROWS;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_SOURCE_WIDTH:  src_w_reg <= cfg_data;
                REG_SOURCE_HEIGHT: src_h_reg <= cfg_data;
                REG_TEXT_COLUMNS:  cols_reg  <= cfg_data;
                REG_TEXT_ROWS:     rows_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // effective sizes, registered from the clamped raw values
    logic [DW-1:0] sw_clamp, sh_clamp;
    logic [DW-1:0] sw_reg, sh_reg, tw_reg, th_reg;

    assign sw_clamp = clamp_dim(XW'(src_w_reg), XW'(MAX_DIMENSION));
    assign sh_clamp = clamp_dim(XW'(src_h_reg), XW'(MAX_DIMENSION));

    always_ff @(posedge aclk) begin
        sw_reg <= sw_clamp;
        sh_reg <= sh_clamp;
        tw_reg <= clamp_dim(XW'(cols_reg), XW'(sw_clamp));
        th_reg <= clamp_dim(XW'(rows_reg), XW'(sh_clamp));
    end

    // frame restart when a reset or a size write reaches pend_reg[1], once sizes have settled
    logic [1:0] pend_reg, pend_next;
    logic       restart;

    assign pend_next = {pend_reg[0], cfg_hit};
    assign restart   = pend_reg[1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= 2'b01;
        end else begin
            pend_reg <= pend_next;
        end
    end

    assign s_tready = !q_full && (pend_reg == 2'b00);

    // position state
    logic [CW-1:0] src_col_reg, src_col_next, src_row_reg, src_row_next;
    logic [DW-1:0] out_col_reg, out_col_next, out_row_reg, out_row_next;
    logic [PW-1:0] col_tgt_reg, col_tgt_next, col_lim_reg, col_lim_next;
    logic [PW-1:0] row_tgt_reg, row_tgt_next, row_lim_reg, row_lim_next;

    logic accept, row_hit, col_hit, last_col, last_row, src_last_col, src_last_row;

    assign accept       = s_tvalid && s_tready;
    assign row_hit      = row_tgt_reg < row_lim_reg;
    assign col_hit      = col_tgt_reg < col_lim_reg;
    assign last_col     = ((DW+1)'(out_col_reg) + (DW+1)'(1)) >= (DW+1)'(tw_reg);
    assign last_row     = ((DW+1)'(out_row_reg) + (DW+1)'(1)) >= (DW+1)'(th_reg);
    assign src_last_col = ((DW+1)'(src_col_reg) + (DW+1)'(1)) >= (DW+1)'(sw_reg);
    assign src_last_row = ((DW+1)'(src_row_reg) + (DW+1)'(1)) >= (DW+1)'(sh_reg);

    always_comb begin
        src_col_next = src_col_reg;
        src_row_next = src_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        col_tgt_next = col_tgt_reg;
        col_lim_next = col_lim_reg;
        row_tgt_next = row_tgt_reg;
        row_lim_next = row_lim_reg;
        if (restart) begin
            src_col_next = '0;
            src_row_next = '0;
            out_col_next = '0;
            out_row_next = '0;
            col_tgt_next = '0;
            col_lim_next = PW'(tw_reg);
            row_tgt_next = '0;
            row_lim_next = PW'(th_reg);
        end else if (accept) begin
            if (src_last_col) begin
                // end of source row
                src_col_next = '0;
                out_col_next = '0;
                col_tgt_next = '0;
                col_lim_next = PW'(tw_reg);
                if (src_last_row) begin
                    src_row_next = '0;
                    out_row_next = '0;
                    row_tgt_next = '0;
                    row_lim_next = PW'(th_reg);
                end else begin
                    src_row_next = src_row_reg + CW'(1);
                    row_lim_next = row_lim_reg + PW'(th_reg);
                    if (row_hit) begin
                        out_row_next = out_row_reg + DW'(1);
                        row_tgt_next = row_tgt_reg + PW'(sh_reg);
                    end
                end
            end else begin
                src_col_next = src_col_reg + CW'(1);
                col_lim_next = col_lim_reg + PW'(tw_reg);
                if (col_hit) begin
                    out_col_next = out_col_reg + DW'(1);
                    col_tgt_next = col_tgt_reg + PW'(sw_reg);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_col_reg <= '0;
            src_row_reg <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            col_tgt_reg <= '0;
            col_lim_reg <= '0;
            row_tgt_reg <= '0;
            row_lim_reg <= '0;
        end else begin
            src_col_reg <= src_col_next;
            src_row_reg <= src_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
            col_tgt_reg <= col_tgt_next;
            col_lim_reg <= col_lim_next;
            row_tgt_reg <= row_tgt_next;
            row_lim_reg <= row_lim_next;
        end
    end

    // sampled pixels go to the queue
    assign q_push            = accept && row_hit && col_hit;
    assign q_item.red        = s_tdata[PIX_W-1:0];
    assign q_item.green      = s_tdata[2*PIX_W-1:PIX_W];
    assign q_item.blue       = s_tdata[3*PIX_W-1:2*PIX_W];
    assign q_item.row_end    = last_col;
    assign q_item.frame_end  = last_col && last_row;

endmodule

@@ src/p2a_queue.sv @@
module p2a_queue import p2a_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  p2a_item_t push_item,
    output logic      full,
    input  logic      pop,
    output logic      not_empty,
    output p2a_item_t head
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int NW = $clog2(QUEUE_DEPTH + 1);

    p2a_item_t     slots [QUEUE_DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    assign full      = count_reg == NW'(QUEUE_DEPTH);
    assign not_empty = count_reg != '0;
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign head      = slots[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + NW'(1);
            2'b01:   count_next = count_reg - NW'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            slots[wr_ptr_reg] <= push_item;
        end
    end

endmodule

@@ src/p2a_back.sv @@
module p2a_back import p2a_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    // from the queue
    input  logic                q_valid,
    input  p2a_item_t           q_item,
    output logic                q_pop,
    // glyph side
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,
    output logic                m_tlast,
    output logic [0:0]          m_tuser
);

    // stage 1: weighted sum
    logic             v1_reg, re1_reg, fe1_reg;
    logic [SUM_W-1:0] sum1_reg;
    // stage 2: divide by 1000
    logic             v2_reg, re2_reg, fe2_reg;
    logic [PIX_W-1:0] luma2_reg;
    // stage 3: output register
    logic               v3_reg, re3_reg, fe3_reg;
    logic [GLYPH_W-1:0] glyph3_reg;

    logic             rdy1, rdy2, rdy3;
    logic [SUM_W-1:0] sum_c;
    logic [PROD_W-1:0] prod_c;

    // each stage moves on when the one after it is free
    assign rdy3  = !v3_reg || m_tready;
    assign rdy2  = !v2_reg || rdy3;
    assign rdy1  = !v1_reg || rdy2;
    assign q_pop = q_valid && rdy1;

    assign sum_c  = SUM_W'(q_item.red) * WEIGHT_R + SUM_W'(q_item.green) * WEIGHT_G
                  + SUM_W'(q_item.blue) * WEIGHT_B;
    assign prod_c = PROD_W'(sum1_reg) * PROD_W'(LUMA_RECIP);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (rdy1) begin
                v1_reg <= q_valid;
            end
            if (rdy2) begin
                v2_reg <= v1_reg;
            end
            if (rdy3) begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1) begin
            sum1_reg <= sum_c;
            re1_reg  <= q_item.row_end;
            fe1_reg  <= q_item.frame_end;
        end
        if (rdy2) begin
            luma2_reg <= prod_c[LUMA_SHIFT +: PIX_W];
            re2_reg   <= re1_reg;
            fe2_reg   <= fe1_reg;
        end
        if (rdy3) begin
            glyph3_reg <= luma_glyph(luma2_reg);
            re3_reg    <= re2_reg;
            fe3_reg    <= fe2_reg;
        end
    end

    assign m_tvalid   = v3_reg;
    assign m_tdata    = M_DATA_W'(glyph3_reg);
    assign m_tlast    = re3_reg;
    assign m_tuser[0] = fe3_reg;

endmodule

@@ src/pixel_to_ascii_downsampler.sv @@
// Channel    Handshake            Payload
// s_  pixel  s_tvalid / s_tready  s_tdata: red, green, blue
// m_  glyph  m_tvalid / m_tready  m_tdata: glyph; m_tlast: row end; m_tuser: frame end
// cfg write  cfg_valid / cfg_ready cfg_index, cfg_data (0 src width, 1 src height,
//                                  2 text columns, 3 text rows)
//
// One pixel per cycle in while s_tready is high and one glyph per cycle out while m_tready
// is high; the classifier settles a pixel in the cycle it is taken, then the glyph leaves
// the queue and a three-stage luma pipeline.
// After reset and after each write to a size register, s_tready stays low while the
// effective sizes settle and the frame position restarts. cfg_ready is always high.
// A stalled m_ side fills the four-entry queue, after which s_tready drops.
module pixel_to_ascii_downsampler import p2a_pkg::*; #(
    parameter int MAX_DIMENSION = DEF_MAX_DIMENSION
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_DATA_W-1:0]  s_tdata,   // [7:0] red, [15:8] green, [23:16] blue
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_DATA_W-1:0]  m_tdata,   // [6:0] glyph, [7] zero
    output logic                 m_tlast,
    output logic [0:0]           m_tuser,   // [0] frame_end
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    logic      q_full, q_push, q_pop, q_not_empty;
    p2a_item_t q_in, q_head;

    assign cfg_ready = 1'b1;

    p2a_front #(
        .MAX_DIMENSION(MAX_DIMENSION)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_item    (q_in)
    );

    p2a_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    p2a_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_not_empty),
        .q_item   (q_head),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps

module tb import p2a_pkg::*; ();

    localparam int SIZE_CAP      = DEF_MAX_DIMENSION;
    localparam int RANDOM_ITEMS  = 1300;
    localparam int SETTLE_CYCLES = 8;
    localparam int STALL_LIMIT   = 2000;
    localparam int PRINT_LIMIT   = 100;

    // indexes past the register list, written to check they change nothing
    localparam logic [CFG_IDX_W-1:0] REG_PAST_LIST = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] REG_TOP_INDEX = '1;

    localparam logic [GLYPH_W-1:0] GLYPH_BLANK = 7'h20;
    localparam logic [GLYPH_W-1:0] GLYPH_FULL  = 7'h4D;

    // shade ramp, dark to bright
    localparam string SHADES = "   ...',;:clodxkO0KXNWM";

    typedef struct packed {
        logic [GLYPH_W-1:0] glyph;
        logic               row_end;
        logic               frame_end;
    } glyph_rec_t;

    typedef enum logic {DO_PIXEL, DO_WRITE} step_kind_t;

    typedef struct packed {
        step_kind_t           kind;
        logic [CFG_IDX_W-1:0] index;
        logic [CFG_W-1:0]     value;
        logic [PIX_W-1:0]     red;
        logic [PIX_W-1:0]     green;
        logic [PIX_W-1:0]     blue;
        logic                 typed;
        glyph_rec_t           want;
    } script_row_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_DATA_W-1:0]  s_tdata   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_DATA_W-1:0]  m_tdata;
    logic                 m_tlast;
    logic [0:0]           m_tuser;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data  = '0;

    pixel_to_ascii_downsampler dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // glyphs owed by the block, oldest first
    glyph_rec_t  glyphs_due[$];
    glyph_rec_t  out_due;
    int          fault_count = 0;
    int          stall_cycles = 0;
    bit          steady = 1'b0;

    // sizes as written
    logic [CFG_W-1:0] cfg_src_w;
    logic [CFG_W-1:0] cfg_src_h;
    logic [CFG_W-1:0] cfg_cols;
    logic [CFG_W-1:0] cfg_rows;

    // raster position and running products
    int unsigned src_col;
    int unsigned src_row;
    int unsigned out_col;
    int unsigned out_row;
    int unsigned col_target;
    int unsigned col_limit;
    int unsigned row_target;
    int unsigned row_limit;

    function automatic int unsigned fit_size(input int unsigned v, input int unsigned cap);
        if (v == 0)
            return 1;
        if (v > cap)
            return cap;
        return v;
    endfunction

    function automatic int unsigned eff_src_w();
        return fit_size(cfg_src_w, SIZE_CAP);
    endfunction

    function automatic int unsigned eff_src_h();
        return fit_size(cfg_src_h, SIZE_CAP);
    endfunction

    function automatic int unsigned eff_cols();
        return fit_size(cfg_cols, eff_src_w());
    endfunction

    function automatic int unsigned eff_rows();
        return fit_size(cfg_rows, eff_src_h());
    endfunction

    function automatic void restart_line();
        src_col    = 0;
        out_col    = 0;
        col_target = 0;
        col_limit  = eff_cols();
    endfunction

    function automatic void restart_frame();
        restart_line();
        src_row    = 0;
        out_row    = 0;
        row_target = 0;
        row_limit  = eff_rows();
    endfunction

    // walks one pixel through the sampling grid; returns 1 when it yields a glyph
    function automatic bit sample_pixel(input logic [PIX_W-1:0] r, input logic [PIX_W-1:0] g,
                                        input logic [PIX_W-1:0] b, output glyph_rec_t res);
        int unsigned sw;
        int unsigned sh;
        int unsigned tw;
        int unsigned th;
        int unsigned luma;
        int unsigned shade;
        byte         ch;
        bit          row_hit;
        bit          col_hit;
        sw      = eff_src_w();
        sh      = eff_src_h();
        tw      = eff_cols();
        th      = eff_rows();
        row_hit = row_target < row_limit;
        col_hit = col_target < col_limit;
        res     = '0;
        if (row_hit && col_hit) begin
            luma  = (299 * int'(r) + 587 * int'(g) + 114 * int'(b)) / 1000;
            shade = luma * 22 / 255;
            if (shade > 22)
                shade = 22;
            ch            = SHADES[shade];
            res.glyph     = ch[GLYPH_W-1:0];
            res.row_end   = (out_col + 1) >= tw;
            res.frame_end = res.row_end && ((out_row + 1) >= th);
        end
        if (col_hit) begin
            out_col++;
            col_target += sw;
        end
        col_limit += tw;
        // end of a source row
        if (src_col + 1 >= sw) begin
            restart_line();
            if (row_hit) begin
                out_row++;
                row_target += sh;
            end
            row_limit += th;
            if (src_row + 1 >= sh)
                restart_frame();
            else
                src_row++;
        end else begin
            src_col++;
        end
        return row_hit && col_hit;
    endfunction

    function automatic void reset_model();
        cfg_src_w = RST_SOURCE_WIDTH;
        cfg_src_h = RST_SOURCE_HEIGHT;
        cfg_cols  = RST_TEXT_COLUMNS;
        cfg_rows  = RST_TEXT_ROWS;
        restart_frame();
    endfunction

    task automatic flag_fault(input string what);
        fault_count++;
        if (fault_count <= PRINT_LIMIT)
            $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    // a pixel transfer; valid is left high for the next one
    task automatic send_pixel(input logic [PIX_W-1:0] r, input logic [PIX_W-1:0] g,
                              input logic [PIX_W-1:0] b, input logic typed,
                              input glyph_rec_t want);
        glyph_rec_t res;
        bit         kept;
        if (!steady && $urandom_range(99) < 15) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {b, g, r};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        kept = sample_pixel(r, g, b, res);
        if (typed)
            glyphs_due.push_back(want);
        else if (kept)
            glyphs_due.push_back(res);
    endtask

    // register write; valid is left high so back-to-back writes need no gap
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_W-1:0] val);
        bit known;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        known = 1'b1;
        case (idx)
            REG_SOURCE_WIDTH:  cfg_src_w = val;
            REG_SOURCE_HEIGHT: cfg_src_h = val;
            REG_TEXT_COLUMNS:  cfg_cols  = val;
            REG_TEXT_ROWS:     cfg_rows  = val;
            default:           known = 1'b0;
        endcase
        if (known)
            restart_frame();
    endtask

    // hold the pixel stream until every owed glyph has left
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (glyphs_due.size() != 0);
    endtask

    task automatic quiesce_for_write();
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic script_row_t pixel_row(input logic [PIX_W-1:0] r,
                                              input logic [PIX_W-1:0] g,
                                              input logic [PIX_W-1:0] b);
        script_row_t row;
        row       = '0;
        row.kind  = DO_PIXEL;
        row.red   = r;
        row.green = g;
        row.blue  = b;
        return row;
    endfunction

    function automatic script_row_t typed_row(input logic [PIX_W-1:0] r,
                                              input logic [PIX_W-1:0] g,
                                              input logic [PIX_W-1:0] b,
                                              input logic [GLYPH_W-1:0] glyph,
                                              input logic re, input logic fe);
        script_row_t row;
        row                = pixel_row(r, g, b);
        row.typed          = 1'b1;
        row.want.glyph     = glyph;
        row.want.row_end   = re;
        row.want.frame_end = fe;
        return row;
    endfunction

    function automatic script_row_t write_row(input logic [CFG_IDX_W-1:0] idx,
                                              input logic [CFG_W-1:0] val);
        script_row_t row;
        row       = '0;
        row.kind  = DO_WRITE;
        row.index = idx;
        row.value = val;
        return row;
    endfunction

    function automatic logic [CFG_W-1:0] rim_size();
        case ($urandom_range(4))
            0:       return '0;
            1:       return CFG_W'(1);
            2:       return CFG_W'(SIZE_CAP);
            3:       return '1;
            default: return CFG_W'($urandom);
        endcase
    endfunction

    function automatic logic [PIX_W-1:0] pick_channel();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            default: return PIX_W'($urandom);
        endcase
    endfunction

    // receiver back-pressure
    always @(posedge aclk)
        m_tready <= steady || ($urandom_range(99) >= 25);

    // glyph checker
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (glyphs_due.size() == 0) begin
                flag_fault($sformatf("glyph %02h with nothing owed", m_tdata));
            end else begin
                out_due = glyphs_due.pop_front();
                if (m_tdata !== {1'b0, out_due.glyph})
                    flag_fault($sformatf("tdata %02h, want %02h", m_tdata, out_due.glyph));
                if (m_tlast !== out_due.row_end)
                    flag_fault($sformatf("row end %b, want %b", m_tlast, out_due.row_end));
                if (m_tuser[0] !== out_due.frame_end)
                    flag_fault($sformatf("frame end %b, want %b", m_tuser[0],
                                         out_due.frame_end));
            end
        end
    end

    // watchdog: no transfer of any kind for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("tb failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin : stimulus
        script_row_t      script[$];
        bit               prev_write;
        int               phase;
        int               sent;
        int               count;
        int               writes;
        int unsigned      frame;
        logic [CFG_W-1:0] w;
        logic [CFG_W-1:0] h;
        logic [CFG_W-1:0] c;
        logic [CFG_W-1:0] r;

        reset_model();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // reset sizes: first pixel is sampled, its neighbour is skipped
        script.push_back(typed_row(8'h00, 8'h00, 8'h00, GLYPH_BLANK, 1'b0, 1'b0));
        script.push_back(pixel_row(8'hFF, 8'hFF, 8'hFF));
        // zero sizes act as one: every pixel ends a row and a frame
        script.push_back(write_row(REG_SOURCE_WIDTH, '0));
        script.push_back(write_row(REG_SOURCE_HEIGHT, '0));
        script.push_back(write_row(REG_TEXT_COLUMNS, '0));
        script.push_back(write_row(REG_TEXT_ROWS, '0));
        script.push_back(typed_row(8'hFF, 8'hFF, 8'hFF, GLYPH_FULL, 1'b1, 1'b1));
        script.push_back(typed_row(8'h00, 8'h00, 8'h00, GLYPH_BLANK, 1'b1, 1'b1));
        script.push_back(pixel_row(8'hFF, 8'h00, 8'h00));
        script.push_back(pixel_row(8'h00, 8'hFF, 8'h00));
        script.push_back(pixel_row(8'h00, 8'h00, 8'hFF));
        script.push_back(pixel_row(8'h80, 8'h80, 8'h80));
        // text wider than source is clamped; writes past the list are no-ops
        script.push_back(write_row(REG_TEXT_COLUMNS, '1));
        script.push_back(write_row(REG_PAST_LIST, CFG_W'(7)));
        script.push_back(write_row(REG_TOP_INDEX, '1));
        script.push_back(typed_row(8'hFF, 8'hFF, 8'hFF, GLYPH_FULL, 1'b1, 1'b1));
        // oversized sizes saturate at the cap
        script.push_back(write_row(REG_SOURCE_WIDTH, '1));
        script.push_back(write_row(REG_TEXT_COLUMNS, CFG_W'(SIZE_CAP)));
        script.push_back(write_row(REG_SOURCE_HEIGHT, CFG_W'(SIZE_CAP)));
        script.push_back(write_row(REG_TEXT_ROWS, '1));
        script.push_back(typed_row(8'hFF, 8'hFF, 8'hFF, GLYPH_FULL, 1'b0, 1'b0));
        script.push_back(typed_row(8'h00, 8'h00, 8'h00, GLYPH_BLANK, 1'b0, 1'b0));
        script.push_back(pixel_row(8'hAA, 8'h55, 8'h33));
        script.push_back(pixel_row(8'h01, 8'h02, 8'h03));
        // 3x2 source down to 2x1 text
        script.push_back(write_row(REG_SOURCE_WIDTH, CFG_W'(3)));
        script.push_back(write_row(REG_SOURCE_HEIGHT, CFG_W'(2)));
        script.push_back(write_row(REG_TEXT_COLUMNS, CFG_W'(2)));
        script.push_back(write_row(REG_TEXT_ROWS, CFG_W'(1)));
        script.push_back(pixel_row(8'hC8, 8'h64, 8'h32));
        script.push_back(pixel_row(8'h3C, 8'h46, 8'h50));
        script.push_back(pixel_row(8'hFF, 8'hFF, 8'h00));
        script.push_back(pixel_row(8'h00, 8'hFF, 8'hFF));
        script.push_back(pixel_row(8'hFF, 8'h00, 8'hFF));
        script.push_back(pixel_row(8'h21, 8'h42, 8'h63));

        prev_write = 1'b0;
        foreach (script[i]) begin
            if (script[i].kind == DO_WRITE) begin
                if (!prev_write)
                    quiesce_for_write();
                write_register(script[i].index, script[i].value);
            end else begin
                if (prev_write)
                    cfg_valid <= 1'b0;
                send_pixel(script[i].red, script[i].green, script[i].blue,
                           script[i].typed, script[i].want);
            end
            prev_write = (script[i].kind == DO_WRITE);
        end

        // random phases: new sizes, then random pixels, whole frames when a frame holds at most 100
        phase = 0;
        sent  = 0;
        while (sent < RANDOM_ITEMS) begin
            steady = (phase == 4 || phase == 5);
            if ($urandom_range(9) == 0) begin
                w = rim_size();
                h = rim_size();
                c = rim_size();
                r = rim_size();
            end else begin
                w = CFG_W'($urandom_range(12, 1));
                h = CFG_W'($urandom_range(10, 1));
                c = CFG_W'($urandom_range(int'(w) + 2, 0));
                r = CFG_W'($urandom_range(int'(h) + 2, 0));
            end

            quiesce_for_write();
            writes = 0;
            if ($urandom_range(3) != 0) begin
                write_register(REG_SOURCE_WIDTH, w);
                writes++;
            end
            if ($urandom_range(3) != 0) begin
                write_register(REG_SOURCE_HEIGHT, h);
                writes++;
            end
            if ($urandom_range(3) != 0) begin
                write_register(REG_TEXT_COLUMNS, c);
                writes++;
            end
            if ($urandom_range(3) != 0) begin
                write_register(REG_TEXT_ROWS, r);
                writes++;
            end
            if (writes == 0)
                write_register(REG_SOURCE_WIDTH, w);
            if ($urandom_range(3) == 0)
                write_register(CFG_IDX_W'($urandom_range(255, 4)), CFG_W'($urandom));
            cfg_valid <= 1'b0;

            frame = eff_src_w() * eff_src_h();
            if (frame <= 100)
                count = int'(frame) * $urandom_range(3, 1);
            else
                count = $urandom_range(150, 30);

            for (int k = 0; k < count; k++) begin
                // sender holds off mid-frame until the block has caught up
                if (phase == 2 && k == count / 2)
                    wait_drained();
                send_pixel(pick_channel(), pick_channel(), pick_channel(), 1'b0, '0);
            end
            sent += count;
            phase++;
        end

        steady = 1'b0;
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (fault_count == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
